[rtl/core/spq_pkg.sv]
// Package for the stable sorted priority queue.
// Holds command and status codes, the cell control bundle and the result layout.
// Used by spq_cell, spq_out_buf and stable_priority_queue_unit.
package spq_pkg;

   localparam int ValueWidth = 32;
   localparam int PrioWidth  = 16;
   localparam int FillWidth  = 5;
   localparam int ReqWidth   = 56;
   localparam int RspWidth   = 40;

   typedef enum logic [1:0] {
      CMD_ENQ  = 2'd0,
      CMD_DEQ  = 2'd1,
      CMD_PEEK = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2
   } status_type;

   typedef struct packed {
      logic                         enq;
      logic                         deq;
      logic signed [PrioWidth-1:0]  prio;
      logic signed [ValueWidth-1:0] value;
   } cell_ctrl_type;

   typedef struct packed {
      logic [FillWidth-1:0]         fill_count;
      status_type                   status;
      logic signed [ValueWidth-1:0] head_value;
   } rsp_type;

endpackage

[rtl/core/spq_cell.sv]
// One slot of the sorted queue chain: holds a value and priority pair.
// Depends on spq_pkg; neighbors are other spq_cell instances.
module spq_cell (
   input  logic                                 clock,
   input  spq_pkg::cell_ctrl_type               ctrl,
   input  logic                                 occupied,
   input  logic                                 left_keep,
   input  logic signed [spq_pkg::ValueWidth-1:0] left_value,
   input  logic signed [spq_pkg::PrioWidth-1:0]  left_prio,
   input  logic signed [spq_pkg::ValueWidth-1:0] right_value,
   input  logic signed [spq_pkg::PrioWidth-1:0]  right_prio,
   output logic                                 keep,
   output logic signed [spq_pkg::ValueWidth-1:0] value,
   output logic signed [spq_pkg::PrioWidth-1:0]  prio
);
   import spq_pkg::*;

   logic signed [ValueWidth-1:0] value_ff, value_in;
   logic signed [PrioWidth-1:0]  prio_ff, prio_in;

   // An entry stays in place on insert when it is held and not ranked after the new pair.
   assign keep = occupied && (prio_ff <= ctrl.prio);

   always_comb begin
      value_in = value_ff;
      prio_in  = prio_ff;
      if (ctrl.enq) begin
         if (!keep) begin
            if (left_keep) begin
               value_in = ctrl.value;
               prio_in  = ctrl.prio;
            end else begin
               value_in = left_value;
               prio_in  = left_prio;
            end
         end
      end else if (ctrl.deq) begin
         value_in = right_value;
         prio_in  = right_prio;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      prio_ff  <= prio_in;
   end

   assign value = value_ff;
   assign prio  = prio_ff;

endmodule

[rtl/core/spq_out_buf.sv]
// Two-entry output register with skid stage for queue responses.
// Depends on spq_pkg for the response layout.
module spq_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  spq_pkg::rsp_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output spq_pkg::rsp_type out_data
);
   import spq_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    take;
   logic    put;

   assign in_ready = !skid_valid_ff;
   assign put      = in_valid && in_ready;
   assign take     = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (put) begin
         if (!main_valid_ff || take) begin
            main_in       = in_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

[rtl/core/stable_priority_queue_unit.sv]
// Top level of the stable sorted priority queue: command decode, fill count, cell chain.
// Depends on spq_pkg, spq_cell and spq_out_buf.
//
//   Channel  Direction  Payload
//   req_     in         cmd, item_value, item_priority
//   rsp_     out        head_value, status, fill_count
//
// Each request is decoded and applied to the cell chain in the cycle it is accepted,
// so one request per cycle is sustained while the output buffer has room; the response
// is registered there. The rate rests on the combinational compare across all cells.
// Reset empties the queue by clearing the fill count; entry contents are not cleared.
// A stalled response channel is absorbed by a two-entry output buffer; requests stop
// only when both entries hold responses.
module stable_priority_queue_unit #(
   parameter int DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // cmd [1:0], item_value [33:2], item_priority [49:34], zeros above
   input  logic [spq_pkg::ReqWidth-1:0] req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // head_value [31:0], status [33:32], fill_count [38:34], zero at bit 39
   output logic [spq_pkg::RspWidth-1:0] rsp_tdata
);
   import spq_pkg::*;

   localparam int CountWidth = $clog2(DEPTH + 1);

   logic [CountWidth-1:0]        count_ff, count_in;
   logic                         accept;
   cmd_type                      cmd;
   logic signed [ValueWidth-1:0] req_value;
   logic signed [PrioWidth-1:0]  req_prio;
   logic                         full;
   logic                         empty;
   cell_ctrl_type                ctrl;
   rsp_type                      rsp;
   rsp_type                      rsp_out;

   logic signed [ValueWidth-1:0] cell_value [DEPTH];
   logic signed [PrioWidth-1:0]  cell_prio [DEPTH];
   logic                         cell_keep [DEPTH];

   assign cmd       = cmd_type'(req_tdata[1:0]);
   assign req_value = req_tdata[33:2];
   assign req_prio  = req_tdata[49:34];
   assign accept    = req_tvalid && req_tready;
   assign full      = (count_ff == CountWidth'(DEPTH));
   assign empty     = (count_ff == '0);

   always_comb begin
      ctrl.enq       = 1'b0;
      ctrl.deq       = 1'b0;
      ctrl.prio      = req_prio;
      ctrl.value     = req_value;
      count_in       = count_ff;
      rsp.head_value = '0;
      rsp.status     = ST_OK;
      case (cmd)
         CMD_ENQ: begin
            if (full) begin
               rsp.status = ST_OVER;
            end else begin
               ctrl.enq = accept;
               count_in = count_ff + CountWidth'(1);
            end
         end
         CMD_DEQ: begin
            if (empty) begin
               rsp.status = ST_UNDER;
            end else begin
               ctrl.deq       = accept;
               count_in       = count_ff - CountWidth'(1);
               rsp.head_value = cell_value[0];
            end
         end
         CMD_PEEK: begin
            if (empty) begin
               rsp.status = ST_UNDER;
            end else begin
               rsp.head_value = cell_value[0];
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      rsp.fill_count = FillWidth'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                         occupied;
      logic                         left_keep;
      logic signed [ValueWidth-1:0] left_value;
      logic signed [PrioWidth-1:0]  left_prio;
      logic signed [ValueWidth-1:0] right_value;
      logic signed [PrioWidth-1:0]  right_prio;

      assign occupied = (CountWidth'(i) < count_ff);

      if (i == 0) begin : g_first
         assign left_keep  = 1'b1;
         assign left_value = req_value;
         assign left_prio  = req_prio;
      end else begin : g_inner
         assign left_keep  = cell_keep[i-1];
         assign left_value = cell_value[i-1];
         assign left_prio  = cell_prio[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_value = cell_value[i];
         assign right_prio  = cell_prio[i];
      end else begin : g_mid
         assign right_value = cell_value[i+1];
         assign right_prio  = cell_prio[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occupied),
         .left_keep   (left_keep),
         .left_value  (left_value),
         .left_prio   (left_prio),
         .right_value (right_value),
         .right_prio  (right_prio),
         .keep        (cell_keep[i]),
         .value       (cell_value[i]),
         .prio        (cell_prio[i])
      );
   end

   spq_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (rsp),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_out)
   );

   assign rsp_tdata = {1'b0, rsp_out.fill_count, rsp_out.status, rsp_out.head_value};

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for stable_priority_queue_unit, a sorted and stable priority queue.
// A shadow queue in the bench predicts every response. It depends on spq_pkg and the unit.
module tb;
   import spq_pkg::*;

   localparam int         Depth      = 16;
   localparam logic [1:0] CmdUnused  = 2'd3;
   localparam int         CycleLimit = 400000;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqWidth-1:0] req_tdata  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspWidth-1:0] rsp_tdata;

   logic signed [ValueWidth-1:0] shadow_values [Depth];
   logic signed [PrioWidth-1:0]  shadow_prios [Depth];
   int                           shadow_fill;
   rsp_type                      predicted_rsp [$];

   int fail_count;
   int cycle_count;
   int stall_left;
   bit idle_on;

   stable_priority_queue_unit #(
      .DEPTH(Depth)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic rsp_type apply_request(input logic [1:0] cmd,
                                             input logic signed [ValueWidth-1:0] value,
                                             input logic signed [PrioWidth-1:0] prio);
      rsp_type r;
      int      pos;
      r.head_value = '0;
      r.status     = ST_OK;
      case (cmd)
         CMD_ENQ: begin
            if (shadow_fill >= Depth) begin
               r.status = ST_OVER;
            end else begin
               pos = 0;
               while (pos < shadow_fill && shadow_prios[pos] <= prio) pos++;
               for (int i = shadow_fill; i > pos; i--) begin
                  shadow_values[i] = shadow_values[i-1];
                  shadow_prios[i]  = shadow_prios[i-1];
               end
               shadow_values[pos] = value;
               shadow_prios[pos]  = prio;
               shadow_fill++;
            end
         end
         CMD_DEQ, CMD_PEEK: begin
            if (shadow_fill == 0) begin
               r.status = ST_UNDER;
            end else begin
               r.head_value = shadow_values[0];
               if (cmd == CMD_DEQ) begin
                  for (int i = 1; i < shadow_fill; i++) begin
                     shadow_values[i-1] = shadow_values[i];
                     shadow_prios[i-1]  = shadow_prios[i];
                  end
                  shadow_fill--;
               end
            end
         end
         default: ;
      endcase
      r.fill_count = shadow_fill[FillWidth-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      fail_count++;
      $display("%0t mismatch in %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            predicted_rsp.push_back(apply_request(req_tdata[1:0], req_tdata[33:2],
                                                  req_tdata[49:34]));
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_rsp.size() == 0) begin
               report_mismatch("response with no request pending", rsp_tdata[31:0], '0);
            end else begin
               want = predicted_rsp.pop_front();
               if (rsp_tdata[31:0] !== want.head_value)
                  report_mismatch("head_value", rsp_tdata[31:0], want.head_value);
               if (rsp_tdata[33:32] !== want.status)
                  report_mismatch("status", 32'(rsp_tdata[33:32]), 32'(want.status));
               if (rsp_tdata[38:34] !== want.fill_count)
                  report_mismatch("fill_count", 32'(rsp_tdata[38:34]),
                                  32'(want.fill_count));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (idle_on && stall_left == 0 && $urandom_range(0, 7) == 0)
         stall_left = $urandom_range(1, 11);
      if (idle_on && stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("FAIL stable_priority_queue_unit");
         $finish;
      end
   end

   task automatic send_request(input logic [1:0] cmd, input logic [31:0] value,
                               input logic [15:0] prio);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 11);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, prio, value, cmd};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_until_drained;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (predicted_rsp.size() != 0);
   endtask

   function automatic logic [15:0] random_prio;
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(0, 4)) - 2);
         2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
         default: return 16'($urandom_range(0, 7));
      endcase
   endfunction

   task automatic test_empty_queue;
      send_request(CMD_PEEK, $urandom, random_prio());
      send_request(CMD_DEQ, $urandom, random_prio());
      send_request(CmdUnused, $urandom, random_prio());
   endtask

   task automatic test_extremes_and_ties;
      send_request(CMD_ENQ, 32'h7fff_ffff, 16'h7fff);
      send_request(CMD_ENQ, 32'h8000_0000, 16'h8000);
      send_request(CMD_ENQ, 32'h0000_0000, 16'h0000);
      send_request(CMD_ENQ, 32'h0000_0001, 16'hffff);
      send_request(CMD_ENQ, 32'h0000_0002, 16'hffff);
      send_request(CMD_ENQ, 32'h0000_0003, 16'hffff);
      send_request(CMD_ENQ, 32'hffff_ffff, 16'h0000);
      send_request(CMD_PEEK, 32'hffff_ffff, 16'hffff);
      send_request(CmdUnused, 32'hffff_ffff, 16'hffff);
      repeat (8) send_request(CMD_DEQ, $urandom, random_prio());
   endtask

   task automatic test_fill_and_drain(input int rounds);
      repeat (rounds) begin
         repeat (Depth + $urandom_range(1, 3)) begin
            if ($urandom_range(0, 9) == 0)
               send_request($urandom_range(0, 1) ? CMD_PEEK : CmdUnused, $urandom,
                            random_prio());
            send_request(CMD_ENQ, $urandom, random_prio());
         end
         repeat (Depth + $urandom_range(1, 2)) begin
            if ($urandom_range(0, 9) == 0)
               send_request(CMD_PEEK, $urandom, random_prio());
            send_request(CMD_DEQ, $urandom, random_prio());
         end
      end
   endtask

   task automatic test_random_mix(input int count);
      int         pick;
      int         enq_share;
      logic [1:0] cmd;
      for (int n = 0; n < count; n++) begin
         enq_share = ((n / 40) % 2) ? 30 : 65;
         pick = $urandom_range(0, 99);
         if (pick < enq_share)
            cmd = CMD_ENQ;
         else if (pick < 85)
            cmd = CMD_DEQ;
         else if (pick < 96)
            cmd = CMD_PEEK;
         else
            cmd = CmdUnused;
         send_request(cmd, $urandom, random_prio());
      end
   endtask

   initial begin
      idle_on = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_empty_queue;
      test_extremes_and_ties;
      test_fill_and_drain(15);
      wait_until_drained;
      test_random_mix(600);
      wait_until_drained;
      idle_on = 1'b0;
      test_random_mix(250);
      wait_until_drained;
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS stable_priority_queue_unit");
      end else begin
         $display("FAIL stable_priority_queue_unit");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/spq_out_buf.sv
rtl/core/stable_priority_queue_unit.sv
tb/sv/tb.sv
